@@ hdl/sdtq_pkg.sv @@
package sdtq_pkg;

   // Sizing of the timer store.
   localparam int SLOTS       = 16;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 16;

   // Field widths of the two channels.
   localparam int KIND_W     = 2;
   localparam int SLOT_FLD_W = 4;
   localparam int TIME_FLD_W = 32;
   localparam int STATUS_W   = 3;

   // Slot index and list position widths.
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0]     slot_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_ADJUST = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 3'd0,
      ST_EXPIRED  = 3'd1,
      ST_NONE     = 3'd2,
      ST_BUSY     = 3'd3,
      ST_INACTIVE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_CLR,
      IDX_INC
   } idx_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      idx_op_type idx_op;
      logic       save_pos;
      logic       write_dl;
      logic       set_act;
      logic       clr_act;
      logic       ins;
      logic       rm;
      logic       pop;
      logic       load;
      status_type rsp_status;
      logic       rsp_last;
      logic       rsp_head;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     slot_ok;
      logic     slot_act;
      logic     idx_lt_cnt;
      logic     later;
      logic     hit;
      logic     move;
      logic     full;
      logic     head_due;
      logic     next_due;
      logic     n_last;
      logic     rsp_free;
   } stat_type;

endpackage

@@ hdl/sdtq_req_if.sv @@
interface sdtq_req_if;
   logic                             valid;
   logic                             ready;
   logic [sdtq_pkg::KIND_W-1:0]      kind;
   logic [sdtq_pkg::SLOT_FLD_W-1:0]  timer_slot;
   logic [sdtq_pkg::TIME_FLD_W-1:0]  deadline;
   logic [sdtq_pkg::TIME_FLD_W-1:0]  now_time;

   modport source (output valid, output kind, output timer_slot, output deadline,
                   output now_time, input ready);
   modport sink (input valid, input kind, input timer_slot, input deadline,
                 input now_time, output ready);
endinterface

@@ hdl/sdtq_rsp_if.sv @@
interface sdtq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sdtq_pkg::STATUS_W-1:0]    status;
   logic [sdtq_pkg::SLOT_FLD_W-1:0]  expired_slot;
   logic                             last_result;

   modport source (output valid, output status, output expired_slot,
                   output last_result, input ready);
   modport sink (input valid, input status, input expired_slot,
                 input last_result, output ready);
endinterface

@@ hdl/sdtq_dpath.sv @@
module sdtq_dpath (
   input  logic              clock,
   input  logic              reset,
   sdtq_req_if.sink          req_if,
   sdtq_rsp_if.source        rsp_if,
   input  sdtq_pkg::cmd_type cmd,
   output sdtq_pkg::stat_type stat
);
   import sdtq_pkg::*;

   kind_type   kind_ff;
   slot_type   slot_ff;
   logic       slot_ok_ff;
   time_type   dl_ff;
   time_type   now_ff;
   time_type   dline_ff [SLOTS];
   time_type   dline_in [SLOTS];
   logic       act_ff [SLOTS];
   logic       act_in [SLOTS];
   slot_type   ord_ff [SLOTS];
   slot_type   ord_in [SLOTS];
   cnt_type    cnt_ff;
   cnt_type    cnt_in;
   cnt_type    idx_ff;
   cnt_type    idx_in;
   slot_type   pos_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type rsp_status_ff;
   logic [SLOT_FLD_W-1:0] rsp_slot_ff;
   logic       rsp_last_ff;

   slot_type rd_ord;
   time_type rd_dl;
   slot_type head;
   time_type head_dl;
   time_type nxt_dl;
   slot_type rm_pos;
   logic     rsp_free;

   // Single walk read port plus fixed reads of the two front entries.
   assign rd_ord  = ord_ff[idx_ff[IDX_W-1:0]];
   assign rd_dl   = dline_ff[rd_ord];
   assign head    = ord_ff[0];
   assign head_dl = dline_ff[head];
   assign nxt_dl  = dline_ff[ord_ff[1]];
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // Status toward the controller.
   always_comb begin
      stat.kind       = kind_ff;
      stat.slot_ok    = slot_ok_ff;
      stat.slot_act   = act_ff[slot_ff];
      stat.idx_lt_cnt = idx_ff < cnt_ff;
      stat.later      = rd_dl > dl_ff;
      stat.hit        = rd_ord == slot_ff;
      stat.move       = dl_ff >= rd_dl;
      stat.full       = cnt_ff == CNT_W'(SLOTS);
      stat.head_due   = (cnt_ff != '0) && (head_dl <= now_ff);
      stat.next_due   = (cnt_ff > CNT_W'(1)) && (nxt_dl <= now_ff);
      stat.n_last     = idx_ff == CNT_W'(MAX_RESULTS - 1);
      stat.rsp_free   = rsp_free;
   end

   // Next values of the deadline store, active flags and ordered list.
   always_comb begin
      rm_pos = cmd.pop ? '0 : pos_ff;
      cnt_in = cnt_ff;
      for (int i = 0; i < SLOTS; i++) begin
         dline_in[i] = dline_ff[i];
         act_in[i]   = act_ff[i];
         ord_in[i]   = ord_ff[i];
      end
      if (cmd.write_dl) begin
         dline_in[slot_ff] = dl_ff;
      end
      if (cmd.set_act) begin
         act_in[slot_ff] = 1'b1;
      end
      if (cmd.clr_act) begin
         act_in[slot_ff] = 1'b0;
      end
      if (cmd.pop) begin
         act_in[head] = 1'b0;
      end
      // Insertion opens a gap at the walk position and shifts the tail up.
      if (cmd.ins) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (CNT_W'(i) == idx_ff) begin
               ord_in[i] = slot_ff;
            end else if (CNT_W'(i) > idx_ff && CNT_W'(i) <= cnt_ff && i > 0) begin
               ord_in[i] = ord_ff[(i > 0) ? i - 1 : 0];
            end
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
      // Removal closes the gap by shifting the tail down.
      if (cmd.rm || cmd.pop) begin
         for (int i = 0; i < SLOTS - 1; i++) begin
            if (CNT_W'(i) >= CNT_W'(rm_pos) && CNT_W'(i + 1) < cnt_ff) begin
               ord_in[i] = ord_ff[i + 1];
            end
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // Walk counter.
   always_comb begin
      case (cmd.idx_op)
         IDX_CLR: idx_in = '0;
         IDX_INC: idx_in = idx_ff + CNT_W'(1);
         default: idx_in = idx_ff;
      endcase
   end

   // Result register valid flag.
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            act_ff[i] <= 1'b0;
         end
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SLOTS; i++) begin
            act_ff[i] <= act_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      for (int i = 0; i < SLOTS; i++) begin
         dline_ff[i] <= dline_in[i];
         ord_ff[i]   <= ord_in[i];
      end
      if (cmd.capture) begin
         kind_ff    <= kind_type'(req_if.kind);
         slot_ff    <= IDX_W'(req_if.timer_slot);
         slot_ok_ff <= 32'(req_if.timer_slot) < SLOTS;
         dl_ff      <= TIME_BITS'(req_if.deadline);
         now_ff     <= TIME_BITS'(req_if.now_time);
      end
      if (cmd.save_pos) begin
         pos_ff <= idx_ff[IDX_W-1:0];
      end
      if (cmd.load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_slot_ff   <= cmd.rsp_head ? SLOT_FLD_W'(head) : '0;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.expired_slot = rsp_slot_ff;
   assign rsp_if.last_result  = rsp_last_ff;

endmodule

@@ hdl/sdtq_ctrl.sv @@
module sdtq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sdtq_pkg::stat_type stat,
   output sdtq_pkg::cmd_type  cmd
);
   import sdtq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_PLACE,
      S_FIND,
      S_ADJ_CMP,
      S_REMOVE,
      S_TICK,
      S_RESP
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   status_type code_ff;
   status_type code_in;
   logic       tick_last;

   assign req_ready = state_ff == S_IDLE;
   assign tick_last = stat.n_last || !stat.next_due;

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.idx_op     = IDX_HOLD;
      cmd.rsp_status = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.idx_op = IDX_CLR;
            unique case (stat.kind)
               KIND_ADD: begin
                  if (!stat.slot_ok || stat.slot_act) begin
                     code_in  = ST_BUSY;
                     state_in = S_RESP;
                  end else begin
                     cmd.write_dl = 1'b1;
                     cmd.set_act  = 1'b1;
                     code_in      = ST_DONE;
                     state_in     = stat.full ? S_RESP : S_PLACE;
                  end
               end
               KIND_ADJUST: begin
                  if (!stat.slot_ok || !stat.slot_act) begin
                     code_in  = ST_INACTIVE;
                     state_in = S_RESP;
                  end else begin
                     cmd.write_dl = 1'b1;
                     state_in     = S_FIND;
                  end
               end
               KIND_DELETE: begin
                  if (!stat.slot_ok || !stat.slot_act) begin
                     code_in  = ST_INACTIVE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_FIND;
                  end
               end
               default: begin
                  state_in = S_TICK;
               end
            endcase
         end
         // Walk to the first entry with a strictly later deadline.
         S_PLACE: begin
            if (stat.idx_lt_cnt && !stat.later) begin
               cmd.idx_op = IDX_INC;
            end else begin
               cmd.ins  = 1'b1;
               code_in  = ST_DONE;
               state_in = S_RESP;
            end
         end
         // Walk to the slot's position in the list.
         S_FIND: begin
            cmd.idx_op = IDX_INC;
            if (stat.hit) begin
               cmd.save_pos = 1'b1;
               state_in     = (stat.kind == KIND_DELETE) ? S_REMOVE : S_ADJ_CMP;
            end
         end
         // The walk position now points at the successor.
         S_ADJ_CMP: begin
            code_in = ST_DONE;
            if (stat.idx_lt_cnt && stat.move) begin
               cmd.rm     = 1'b1;
               cmd.idx_op = IDX_CLR;
               state_in   = S_PLACE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REMOVE: begin
            cmd.rm      = 1'b1;
            cmd.clr_act = 1'b1;
            code_in     = ST_DONE;
            state_in    = S_RESP;
         end
         // Expire due entries from the front, one transfer each.
         S_TICK: begin
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               if (stat.head_due) begin
                  cmd.pop        = 1'b1;
                  cmd.idx_op     = IDX_INC;
                  cmd.rsp_status = ST_EXPIRED;
                  cmd.rsp_head   = 1'b1;
                  cmd.rsp_last   = tick_last;
                  if (tick_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.rsp_status = ST_NONE;
                  cmd.rsp_last   = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load       = 1'b1;
               cmd.rsp_status = code_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered result code.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ hdl/sorted_deadline_timer_queue.sv @@
// A request is captured when idle, then checked; a refused one goes straight to the result.
// Add walks the ordered list to the first later deadline and inserts the slot there.
// Delete finds the slot and removes it; adjust re-places the slot only if it moves.
// A tick gives results from the list front, one per cycle while the output is free.
// One item is in work at a time; the walk over the ordered list sets the rate.
// Synchronous reset clears the active flags, the entry count and all control state.
module sorted_deadline_timer_queue (
   input logic        clock,
   input logic        reset,
   sdtq_req_if.sink   req_if,
   sdtq_rsp_if.source rsp_if
);
   import sdtq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   sdtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Timer store, ordered list and result register.
   sdtq_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule
